### rtl/cc_cv_charge_pi_controller_unit_macros.svh
// assertion helpers for the charge controller
`ifndef CC_CV_CHARGE_PI_CONTROLLER_UNIT_MACROS_SVH
`define CC_CV_CHARGE_PI_CONTROLLER_UNIT_MACROS_SVH

// checked on every clock edge outside reset
`define CCPI_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// checked only while a result word is on the output
`define CCPI_ASSERT_OUT(label, prop, msg) \
    `CCPI_ASSERT(label, o_out_valid |-> (prop), msg)

`endif

### rtl/ccpi_pkg.sv
package ccpi_pkg;

    // accumulator width, wraps at this many bits
    localparam int ACCUM_W = 32;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // charge modes
    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_CC   = 2'd1;
    localparam logic [1:0] MODE_CV   = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CURRENT_REF = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE_REF = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KP_CURRENT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KI_CURRENT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KP_VOLTAGE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_KI_VOLTAGE  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CURRENT_MIN = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE_MIN = 3'd7;

    // reset values
    localparam logic [15:0] RST_REF     = 16'h0000;
    localparam logic [7:0]  RST_KP      = 8'hF0;
    localparam logic [7:0]  RST_KI      = 8'h0A;
    localparam logic [15:0] RST_MIN     = 16'h000A;
    localparam logic [15:0] RST_CMD_OUT = 16'h00F0;
    localparam logic [15:0] CMD_MAX     = 16'hFFFF;

    typedef struct packed {
        logic [15:0] current_ref;
        logic [15:0] voltage_ref;
        logic [7:0]  kp_current;
        logic [7:0]  ki_current;
        logic [7:0]  kp_voltage;
        logic [7:0]  ki_voltage;
        logic [15:0] current_min;
        logic [15:0] voltage_min;
    } t_cfg;

endpackage

### rtl/ccpi_cfg_regs.sv
module ccpi_cfg_regs
    import ccpi_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.current_ref <= RST_REF;
            r_cfg.voltage_ref <= RST_REF;
            r_cfg.kp_current  <= RST_KP;
            r_cfg.ki_current  <= RST_KI;
            r_cfg.kp_voltage  <= RST_KP;
            r_cfg.ki_voltage  <= RST_KI;
            r_cfg.current_min <= RST_MIN;
            r_cfg.voltage_min <= RST_MIN;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_CURRENT_REF: r_cfg.current_ref <= i_cfg_data;
                REG_VOLTAGE_REF: r_cfg.voltage_ref <= i_cfg_data;
                REG_KP_CURRENT:  r_cfg.kp_current  <= i_cfg_data[7:0];
                REG_KI_CURRENT:  r_cfg.ki_current  <= i_cfg_data[7:0];
                REG_KP_VOLTAGE:  r_cfg.kp_voltage  <= i_cfg_data[7:0];
                REG_KI_VOLTAGE:  r_cfg.ki_voltage  <= i_cfg_data[7:0];
                REG_CURRENT_MIN: r_cfg.current_min <= i_cfg_data;
                REG_VOLTAGE_MIN: r_cfg.voltage_min <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### rtl/ccpi_pi_step.sv
module ccpi_pi_step
    import ccpi_pkg::*;
(
    input  logic [15:0]        i_ref,
    input  logic [15:0]        i_fb,
    input  logic [7:0]         i_kp,
    input  logic [7:0]         i_ki,
    input  logic [15:0]        i_lo,
    input  logic [ACCUM_W-1:0] i_acc,
    output logic [ACCUM_W-1:0] o_acc_next,
    output logic [15:0]        o_cmd
);

    logic [16:0]        err;
    logic [31:0]        err32;
    logic [ACCUM_W-1:0] err_acc;
    logic [63:0]        acc64;
    logic [31:0]        acc32;
    logic [31:0]        p_term;
    logic [31:0]        i_term;
    logic [31:0]        sum;
    logic               over_max;
    logic               under_lo;

    always_comb begin
        // error fits 17 bits signed
        err        = {1'b0, i_ref} - {1'b0, i_fb};
        err32      = {{15{err[16]}}, err};
        err_acc    = {{(ACCUM_W-17){err[16]}}, err};
        o_acc_next = i_acc + err_acc;

        // only the low 32 bits of the integral product matter
        acc64  = {{(64-ACCUM_W){o_acc_next[ACCUM_W-1]}}, o_acc_next};
        acc32  = acc64[31:0];
        p_term = {24'd0, i_kp} * err32;
        i_term = {24'd0, i_ki} * acc32;
        sum    = {16'd0, i_fb} - p_term - i_term;

        // signed clamp to [lo, 65535]
        over_max = !sum[31] && (sum[30:16] != '0);
        under_lo = sum[31] || ((sum[30:16] == '0) && (sum[15:0] < i_lo));
        if (over_max) begin
            o_cmd = CMD_MAX;
        end else if (under_lo) begin
            o_cmd = i_lo;
        end else begin
            o_cmd = sum[15:0];
        end
    end

endmodule

### rtl/cc_cv_charge_pi_controller_unit.sv
// cc/cv charge controller with two pi loops. one word per control tick
// (start request, current sample, voltage sample) gives one result word
// (mode after the tick, held current and voltage commands with their update
// flags, charge done). throughput is one word per clock while the result is
// taken (i_out_ready): the input word is registered, the mode machine and
// the pi step of the active loop (error, accumulator update, two 8 x 32
// products, subtract and clamp) are combinational, and the result lands in
// an output register; a result that waits untaken stalls the step. the
// accumulator feedback loop through that single pi step is what sets the
// rate. the output register lets a new word enter while a finished result
// waits. registers are written through a plain write port (index 0..7:
// current ref, voltage ref, kp/ki current, kp/ki voltage, current min,
// voltage min) and must only change while no word is in flight.
`include "cc_cv_charge_pi_controller_unit_macros.svh"

module cc_cv_charge_pi_controller_unit
    import ccpi_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input words
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_start_req,
    input  logic [15:0]           i_current_fb,
    input  logic [15:0]           i_voltage_fb,
    // result words
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [1:0]            o_mode,
    output logic [15:0]           o_current_cmd,
    output logic                  o_current_cmd_valid,
    output logic [15:0]           o_voltage_cmd,
    output logic                  o_voltage_cmd_valid,
    output logic                  o_charge_done
);

    t_cfg cfg;

    ccpi_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // input register
    logic        r_in_valid;
    logic        r_in_start;
    logic [15:0] r_in_ifb;
    logic [15:0] r_in_vfb;

    // output register
    logic        r_out_valid;
    logic [1:0]  r_out_mode;
    logic [15:0] r_out_ccmd;
    logic        r_out_cval;
    logic [15:0] r_out_vcmd;
    logic        r_out_vval;
    logic        r_out_done;

    // controller state
    logic [1:0]         r_mode;
    logic [ACCUM_W-1:0] r_cacc;
    logic [ACCUM_W-1:0] r_vacc;
    logic [15:0]        r_cout;
    logic [15:0]        r_vout;

    logic [1:0]         n_mode;
    logic [ACCUM_W-1:0] n_cacc;
    logic [ACCUM_W-1:0] n_vacc;
    logic [15:0]        n_cout;
    logic [15:0]        n_vout;
    logic               n_cval;
    logic               n_vval;
    logic               n_done;

    logic               in_fire;
    logic               step;

    logic [ACCUM_W-1:0] cacc_step;
    logic [ACCUM_W-1:0] vacc_step;
    logic [15:0]        ccmd_step;
    logic [15:0]        vcmd_step;

    // a word moves from the input register to the output register
    assign step       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || step;
    assign in_fire    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_start <= i_start_req;
            r_in_ifb   <= i_current_fb;
            r_in_vfb   <= i_voltage_fb;
        end
    end

    ccpi_pi_step u_cur_pi (
        .i_ref      (cfg.current_ref),
        .i_fb       (r_in_ifb),
        .i_kp       (cfg.kp_current),
        .i_ki       (cfg.ki_current),
        .i_lo       (cfg.current_min),
        .i_acc      (r_cacc),
        .o_acc_next (cacc_step),
        .o_cmd      (ccmd_step)
    );

    ccpi_pi_step u_vol_pi (
        .i_ref      (cfg.voltage_ref),
        .i_fb       (r_in_vfb),
        .i_kp       (cfg.kp_voltage),
        .i_ki       (cfg.ki_voltage),
        .i_lo       (cfg.voltage_min),
        .i_acc      (r_vacc),
        .o_acc_next (vacc_step),
        .o_cmd      (vcmd_step)
    );

    // mode machine
    always_comb begin
        n_mode = r_mode;
        n_cacc = r_cacc;
        n_vacc = r_vacc;
        n_cout = r_cout;
        n_vout = r_vout;
        n_cval = 1'b0;
        n_vval = 1'b0;
        n_done = 1'b0;
        case (r_mode)
            MODE_IDLE: begin
                if (r_in_start) begin
                    n_mode = MODE_CC;
                end
            end
            MODE_CC: begin
                // voltage reached its target: hand over, no command this tick
                if (r_in_vfb == cfg.voltage_ref) begin
                    n_mode = MODE_CV;
                    n_cacc = '0;
                end else begin
                    n_cacc = cacc_step;
                    n_cout = ccmd_step;
                    n_cval = 1'b1;
                end
            end
            MODE_CV: begin
                // current tapered off: charge finished
                if (r_in_ifb <= cfg.current_min) begin
                    n_mode = MODE_IDLE;
                    n_vacc = '0;
                    n_done = 1'b1;
                end else begin
                    n_vacc = vacc_step;
                    n_vout = vcmd_step;
                    n_vval = 1'b1;
                end
            end
            default: begin
                n_mode = MODE_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_cacc <= '0;
            r_vacc <= '0;
            r_cout <= RST_CMD_OUT;
            r_vout <= RST_CMD_OUT;
        end else if (step) begin
            r_mode <= n_mode;
            r_cacc <= n_cacc;
            r_vacc <= n_vacc;
            r_cout <= n_cout;
            r_vout <= n_vout;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_mode <= n_mode;
            r_out_ccmd <= n_cout;
            r_out_cval <= n_cval;
            r_out_vcmd <= n_vout;
            r_out_vval <= n_vval;
            r_out_done <= n_done;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_mode              = r_out_mode;
    assign o_current_cmd       = r_out_ccmd;
    assign o_current_cmd_valid = r_out_cval;
    assign o_voltage_cmd       = r_out_vcmd;
    assign o_voltage_cmd_valid = r_out_vval;
    assign o_charge_done       = r_out_done;

    // only one loop updates per tick
    `CCPI_ASSERT_OUT(a_one_loop, !(r_out_cval && r_out_vval), "both loops updated in one tick")
    // a current update means the machine stayed in constant current
    `CCPI_ASSERT_OUT(a_cval_mode, !r_out_cval || (r_out_mode == MODE_CC), "current update outside cc")
    // end of charge lands in idle
    `CCPI_ASSERT_OUT(a_done_idle, !r_out_done || (r_out_mode == MODE_IDLE), "done without idle")
    // end of charge cleared the voltage accumulator
    `CCPI_ASSERT_OUT(a_done_clear, !r_out_done || (r_vacc == '0), "voltage accumulator not cleared")

endmodule
